FILE: design/hamming74_stream_decoder_core_macros.svh
// Assertion macros shared by the decoder RTL files.
`ifndef HAMMING74_STREAM_DECODER_CORE_MACROS_SVH
`define HAMMING74_STREAM_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define HM74_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hm74 same-cycle check failed");
// Next-cycle implication check.
`define HM74_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hm74 next-cycle check failed");
`else
`define HM74_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HM74_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/hm74_pkg.sv
// Types, constants and codeword correction shared by the decoder modules.
`default_nettype none
package hm74_pkg;

    // Result queue depth (two free slots are needed to take a beat).
    localparam int FIFO_DEPTH = 4;

    // Parity check masks over codeword bits 6..0.
    localparam logic [6:0] SYN_MASK0 = 7'b1010101;
    localparam logic [6:0] SYN_MASK1 = 7'b1100110;
    localparam logic [6:0] SYN_MASK2 = 7'b1111000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       format_error;
    } t_result;

    // Results produced by one input beat, r0 first.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r1;
        t_result    r0;
    } t_emit;

    // Correct a single bit error and pull out the four data bits.
    function automatic logic [3:0] fix_codeword(input logic [6:0] cw);
        logic [2:0] syn;
        logic [6:0] c;
        syn[0] = ^(cw & SYN_MASK0);
        syn[1] = ^(cw & SYN_MASK1);
        syn[2] = ^(cw & SYN_MASK2);
        c = cw;
        if (syn != 3'd0) begin
            c = cw ^ (7'd1 << (syn - 3'd1));
        end
        return {c[6], c[5], c[4], c[2]};
    endfunction

endpackage
`default_nettype wire

FILE: design/hm74_if.sv
// Stream channel interfaces for encoded input bytes and decoded results.
`default_nettype none
interface hm74_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hm74_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       format_error;
    modport source (output valid, output out_byte, output out_last, output format_error,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input format_error,
                    output ready);
endinterface
`default_nettype wire

FILE: design/hm74_step.sv
// Decode step: bit gathering, codeword correction and nibble packing state.
`default_nettype none
`include "hamming74_stream_decoder_core_macros.svh"
module hm74_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output hm74_pkg::t_emit  o_emit
);

    logic [6:0] r_code_bits, n_code_bits;
    logic [2:0] r_code_cnt,  n_code_cnt;
    logic [7:0] r_out_bits,  n_out_bits;
    logic [1:0] r_out_cnt,   n_out_cnt;

    logic [3:0]        nbits;
    logic              err;
    logic [8:0]        mask9;
    logic [7:0]        data;
    logic [14:0]       comb15;
    logic [3:0]        total;
    logic [1:0]        ncw;
    logic [3:0]        nib [2];
    logic [6:0]        rem_bits;
    logic [2:0]        rem_cnt;
    logic [7:0]        ob;
    logic [1:0]        oc;
    logic [1:0]        n;
    hm74_pkg::t_result res;
    hm74_pkg::t_result e0, e1;

    // Work out the step for the beat in the input register.
    always_comb begin
        // find the end marker on the last beat
        nbits = 4'd8;
        err   = 1'b0;
        if (i_last) begin
            nbits = 4'd0;
            err   = (i_byte == 8'd0);
            for (int k = 0; k < 8; k++) begin
                if (i_byte[k]) begin
                    nbits = 4'(k);
                end
            end
        end
        mask9  = (9'd1 << nbits) - 9'd1;
        data   = i_byte & mask9[7:0];

        // append the new bits behind the partial codeword
        comb15 = {8'd0, r_code_bits} | ({7'd0, data} << r_code_cnt);
        total  = {1'b0, r_code_cnt} + nbits;
        if (total >= 4'd14) begin
            ncw      = 2'd2;
            rem_bits = 7'd0;
            rem_cnt  = 3'd0;
        end else if (total >= 4'd7) begin
            ncw      = 2'd1;
            rem_bits = comb15[13:7];
            rem_cnt  = 3'(total - 4'd7);
        end else begin
            ncw      = 2'd0;
            rem_bits = comb15[6:0];
            rem_cnt  = 3'(total);
        end
        nib[0] = hm74_pkg::fix_codeword(comb15[6:0]);
        nib[1] = hm74_pkg::fix_codeword(comb15[13:7]);

        // pack nibbles, releasing a held full byte when the next nibble comes
        ob  = r_out_bits;
        oc  = r_out_cnt;
        n   = 2'd0;
        e0  = '0;
        e1  = '0;
        res = '0;
        for (int i = 0; i < 2; i++) begin
            if (2'(i) < ncw) begin
                if (oc == 2'd2) begin
                    res = '{out_byte: ob, out_last: 1'b0, format_error: 1'b0};
                    if (n == 2'd0) e0 = res; else e1 = res;
                    n  = n + 2'd1;
                    ob = 8'd0;
                    oc = 2'd0;
                end
                ob = ob | ({4'd0, nib[i]} << {oc, 2'b00});
                oc = oc + 2'd1;
            end
        end

        // set the next state; on the last beat flush the byte in progress (or an error result) and clear state
        n_code_bits = rem_bits;
        n_code_cnt  = rem_cnt;
        n_out_bits  = ob;
        n_out_cnt   = oc;
        if (i_last) begin
            if (rem_cnt != 3'd0) begin
                err = 1'b1;
            end
            if (oc != 2'd0) begin
                res = '{out_byte: ob, out_last: 1'b1, format_error: err};
                if (n == 2'd0) e0 = res; else e1 = res;
                n = n + 2'd1;
            end else if (err) begin
                res = '{out_byte: 8'd0, out_last: 1'b1, format_error: 1'b1};
                if (n == 2'd0) e0 = res; else e1 = res;
                n = n + 2'd1;
            end
            n_code_bits = 7'd0;
            n_code_cnt  = 3'd0;
            n_out_bits  = 8'd0;
            n_out_cnt   = 2'd0;
        end
    end

    // Hand results to the queue only on an accepted step.
    always_comb begin
        o_emit.cnt = i_fire ? n : 2'd0;
        o_emit.r0  = e0;
        o_emit.r1  = e1;
    end

    // Advance the stream state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= 7'd0;
            r_code_cnt  <= 3'd0;
            r_out_bits  <= 8'd0;
            r_out_cnt   <= 2'd0;
        end else if (i_fire) begin
            r_code_bits <= n_code_bits;
            r_code_cnt  <= n_code_cnt;
            r_out_bits  <= n_out_bits;
            r_out_cnt   <= n_out_cnt;
        end
    end

    `HM74_ASSERT_NOW(a_code_cnt_range, i_clk, i_rst_n, 1'b1, r_code_cnt <= 3'd6)
    `HM74_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_fire && i_last, r_code_cnt == 3'd0 && r_out_cnt == 2'd0 && r_code_bits == 7'd0)
    `HM74_ASSERT_NOW(a_mid_single, i_clk, i_rst_n, i_fire && !i_last, o_emit.cnt <= 2'd1)
    `HM74_ASSERT_NOW(a_err_on_last, i_clk, i_rst_n, o_emit.cnt != 2'd0 && o_emit.r0.format_error, o_emit.r0.out_last)

endmodule
`default_nettype wire

FILE: design/hm74_res_fifo.sv
// Result queue taking up to two results a cycle while two slots are free, and giving one while i_ready is high.
`default_nettype none
`include "hamming74_stream_decoder_core_macros.svh"
module hm74_res_fifo #(
    parameter int DEPTH = hm74_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hm74_pkg::t_emit   i_emit,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output hm74_pkg::t_result o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hm74_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]     r_wr, n_wr;
    logic [PW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [PW-1:0]     wr1;
    logic              pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign pop     = o_valid && i_ready;
    assign wr1     = ptr_inc(r_wr);
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= CW'(DEPTH - 2));
    assign o_data  = r_mem[r_rd];

    // Advance pointers and fill count.
    always_comb begin
        n_rd  = pop ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt + CW'(i_emit.cnt) - CW'(pop);
        unique case (i_emit.cnt)
            2'd0:    n_wr = r_wr;
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = ptr_inc(wr1);
            default: n_wr = r_wr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store incoming results in order.
    always_ff @(posedge i_clk) begin
        if (i_emit.cnt != 2'd0) begin
            r_mem[r_wr] <= i_emit.r0;
        end
        if (i_emit.cnt == 2'd2) begin
            r_mem[wr1] <= i_emit.r1;
        end
    end

    `HM74_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH))
    `HM74_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_emit.cnt != 2'd0, o_room)

endmodule
`default_nettype wire

FILE: design/hamming74_stream_decoder_core.sv
// Top level of the (7,4) streaming block-code decoder.
//
//  channel | dir | fields                            | beat
//  i_in    | in  | in_byte[7:0], in_last             | one encoded byte
//  o_out   | out | out_byte[7:0], out_last, format_error | one decoded byte
//
// One byte is taken per cycle while the result queue has two free slots;
// results leave at one per cycle while o_out.ready is high.
// A byte passes through the input register, then is decoded into the result queue.
// Reset is synchronous and clears the input valid flag, stream state and queue pointers and count.
// A stall on o_out fills the queue and then drops i_in.ready; nothing is lost.
`default_nettype none
module hamming74_stream_decoder_core #(
    parameter int FIFO_DEPTH = hm74_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hm74_in_if.sink     i_in,
    hm74_out_if.source  o_out
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              fire;
    logic              room;
    hm74_pkg::t_emit   emit;
    hm74_pkg::t_result res;

    assign fire       = r_in_vld && room;
    assign i_in.ready = !r_in_vld || fire;

    // Hold the accepted beat until the decode step takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    hm74_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_emit  (emit)
    );

    hm74_res_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (res)
    );

    assign o_out.out_byte     = res.out_byte;
    assign o_out.out_last     = res.out_last;
    assign o_out.format_error = res.format_error;

endmodule
`default_nettype wire
